// ===== rtl/core/dxt_block_decoder_core_assert.svh =====
// Assertion macros for the DXT block decoder core.
// Needs only a clock and an active-low reset in the including module.
`ifndef DXT_BLOCK_DECODER_CORE_ASSERT_SVH
`define DXT_BLOCK_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DXT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dxt core: assertion failed");

// next-cycle implication, disabled while in reset
`define DXT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dxt core: assertion failed");

`endif

// ===== rtl/core/dxt_pkg.sv =====
// Shared types, constants and divide helpers for the DXT block decoder.
// No dependencies; imported by every module of the core.
package dxt_pkg;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2
  } fmt_e;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;

  // reciprocals for exact truncating division over the ranges used here
  localparam logic [20:0] RECIP3   = 21'd683;      // n < 2048, shift 11
  localparam logic [21:0] RECIP5   = 22'd1639;     // n < 2730, shift 13
  localparam logic [22:0] RECIP7   = 23'd2341;     // n < 5461, shift 14
  localparam logic [26:0] EXPAND5K = 27'd2156535;  // 255 * 8457, shift 18
  localparam logic [28:0] EXPAND6K = 29'd4244475;  // 255 * 16645, shift 20

  typedef struct packed {
    logic [63:0] alpha_word;
    logic [63:0] color_word;
  } in_item_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        block_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    fmt_e        fmt;
    logic        four;
    rgb_t        e0;
    rgb_t        e1;
    logic [31:0] cidx;
    logic [63:0] aw;
    logic [2:0]  nx;
    logic [2:0]  ny;
  } blk_t;

  typedef struct packed {
    rgb_t [3:0]       color;
    logic [3:0][7:0]  calpha;
    logic [7:0][7:0]  apal;
  } pal_t;

  typedef struct packed {
    logic busy;
    logic load_ready;
  } emit_stat_t;

  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [20:0] p;
    p = 21'(n) * RECIP3;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [21:0] p;
    p = 22'(n) * RECIP5;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [22:0] p;
    p = 23'(n) * RECIP7;
    return p[21:14];
  endfunction

  // x * 255 / 31, truncating
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [26:0] p;
    p = 27'(x) * EXPAND5K;
    return p[25:18];
  endfunction

  // x * 255 / 63, truncating
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [28:0] p;
    p = 29'(x) * EXPAND6K;
    return p[27:20];
  endfunction

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t v;
    v.r = expand5(c[15:11]);
    v.g = expand6(c[10:5]);
    v.b = expand5(c[4:0]);
    return v;
  endfunction

endpackage

// ===== rtl/core/dxt_pal.sv =====
// Colour and alpha palette builder for one staged block.
// Depends on dxt_pkg for the block and palette types and divide helpers.
module dxt_pal import dxt_pkg::*; (
  input  blk_t blk_i,
  output pal_t pal_o
);

  function automatic logic [7:0] mix3(input logic [7:0] a, input logic [7:0] b);
    return div3({1'b0, a, 1'b0} + {2'b00, b});
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  logic [7:0] a0, a1;

  assign a0 = blk_i.aw[7:0];
  assign a1 = blk_i.aw[15:8];

  always_comb begin
    pal_o.color[0] = blk_i.e0;
    pal_o.color[1] = blk_i.e1;
    if (blk_i.four) begin
      pal_o.color[2].r = mix3(blk_i.e0.r, blk_i.e1.r);
      pal_o.color[2].g = mix3(blk_i.e0.g, blk_i.e1.g);
      pal_o.color[2].b = mix3(blk_i.e0.b, blk_i.e1.b);
      pal_o.color[3].r = mix3(blk_i.e1.r, blk_i.e0.r);
      pal_o.color[3].g = mix3(blk_i.e1.g, blk_i.e0.g);
      pal_o.color[3].b = mix3(blk_i.e1.b, blk_i.e0.b);
    end else begin
      pal_o.color[2].r = half(blk_i.e0.r, blk_i.e1.r);
      pal_o.color[2].g = half(blk_i.e0.g, blk_i.e1.g);
      pal_o.color[2].b = half(blk_i.e0.b, blk_i.e1.b);
      pal_o.color[3]   = '0;
    end
    pal_o.calpha[0] = 8'hFF;
    pal_o.calpha[1] = 8'hFF;
    pal_o.calpha[2] = 8'hFF;
    pal_o.calpha[3] = blk_i.four ? 8'hFF : 8'h00;
  end

  // alpha palette: sevenths when a0 > a1, else fifths plus fully clear and opaque
  always_comb begin
    pal_o.apal = '0;
    pal_o.apal[0] = a0;
    pal_o.apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        pal_o.apal[k+1] = div7(11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        pal_o.apal[k+1] = div5(11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1});
      end
      pal_o.apal[6] = 8'h00;
      pal_o.apal[7] = 8'hFF;
    end
  end

endmodule

// ===== rtl/core/dxt_emit.sv =====
// Texel sweep of a decoded block and palette: one texel a cycle unless stalled.
// Depends on dxt_pkg for block, palette, status and result types.
module dxt_emit import dxt_pkg::*; #(
  parameter int unsigned BLK_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  blk_t             blk_i,
  input  pal_t             pal_i,
  input  logic [BLK_W-1:0] col_i,
  input  logic [BLK_W-1:0] row_i,
  output emit_stat_t       stat_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int unsigned XW = BLK_W + 2;

  logic             em_valid_q, em_valid_d;
  logic [3:0]       tex_q, tex_d;
  blk_t             blk_q;
  pal_t             pal_q;
  logic [BLK_W-1:0] col_q, row_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic       adv, done, load, vis;
  logic [1:0] last_x, last_y;
  logic [1:0] ci_arr  [16];
  logic [3:0] nib_arr [16];
  logic [2:0] aix_arr [16];
  logic [1:0] ci;
  logic [3:0] nib;
  logic [2:0] aix;
  logic [XW-1:0] px, py;
  logic [7:0] alpha;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ci_arr[i]  = blk_q.cidx[2*i +: 2];
      nib_arr[i] = blk_q.aw[4*i +: 4];
      aix_arr[i] = blk_q.aw[16 + 3*i +: 3];
    end
  end

  assign ci  = ci_arr[tex_q];
  assign nib = nib_arr[tex_q];
  assign aix = aix_arr[tex_q];

  // loaded blocks always have at least one visible column and row
  assign last_x = 2'(blk_q.nx - 3'd1);
  assign last_y = 2'(blk_q.ny - 3'd1);
  assign vis    = ({1'b0, tex_q[1:0]} < blk_q.nx) && ({1'b0, tex_q[3:2]} < blk_q.ny);

  assign adv  = em_valid_q && (!out_valid_q || !out_stall_i);
  assign done = adv && (tex_q == {last_y, last_x});
  assign load = load_valid_i && (!em_valid_q || done);

  assign stat_o.busy       = em_valid_q;
  assign stat_o.load_ready = !em_valid_q || done;

  assign px = {col_q, tex_q[1:0]};
  assign py = {row_q, tex_q[3:2]};

  always_comb begin
    unique case (blk_q.fmt)
      FMT_DXT1: alpha = pal_q.calpha[ci];
      FMT_DXT3: alpha = {nib, nib};
      FMT_DXT5: alpha = pal_q.apal[aix];
      default:  alpha = pal_q.apal[aix];
    endcase
  end

  always_comb begin
    em_valid_d  = em_valid_q;
    tex_d       = tex_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      tex_d = tex_q + 4'd1;
      if (vis) begin
        out_valid_d     = 1'b1;
        out_d.pixel_x   = 14'(px);
        out_d.pixel_y   = 14'(py);
        out_d.red       = pal_q.color[ci].r;
        out_d.green     = pal_q.color[ci].g;
        out_d.blue      = pal_q.color[ci].b;
        out_d.alpha     = alpha;
        out_d.block_end = (tex_q == {last_y, last_x});
      end
    end
    if (done) begin
      em_valid_d = 1'b0;
    end
    if (load) begin
      em_valid_d = 1'b1;
      tex_d      = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q  <= 1'b0;
      tex_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      em_valid_q  <= em_valid_d;
      tex_q       <= tex_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) begin
      blk_q <= blk_i;
      pal_q <= pal_i;
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/dxt_block_decoder_core.sv =====
// DXT1/DXT3/DXT5 block decoder: one 4x4 block in, up to sixteen RGBA pixels out.
// Path: a block is staged, loaded into the sweep, and each pixel is registered.
// Throughput: one texel a cycle in the sweep when the output is not stalled;
// a block is swept up to its last visible texel; a fully clipped one is dropped.
// Reset: block counters to zero, format DXT1, width and height 1; no clearing pass.
// Depends on dxt_pkg, dxt_pal, dxt_emit and dxt_block_decoder_core_assert.svh.
`include "dxt_block_decoder_core_assert.svh"

module dxt_block_decoder_core import dxt_pkg::*; #(
  parameter int unsigned MAX_SIDE = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned BLKS   = (MAX_SIDE + 3) / 4;
  localparam int unsigned BLK_W  = (BLKS > 1) ? $clog2(BLKS) : 1;
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW     = (SIDE_W > 15) ? SIDE_W : 15;

  logic [1:0]       fmt_q;
  logic [14:0]      width_q, height_q;
  logic [BLK_W-1:0] col_q, col_d, row_q, row_d;
  logic             s1_valid_q, s1_valid_d;
  blk_t             s1_blk_q, blk_d;
  logic [BLK_W-1:0] s1_col_q, s1_row_q;

  logic             accept, s1_vis, s1_take;
  logic [CW-1:0]    w_eff, h_eff;
  logic [CW:0]      bx_cnt, by_cnt, base_x, base_y, rem_x, rem_y;
  logic [BLK_W:0]   col_inc, row_inc;
  pal_t             pal;
  emit_stat_t       em_stat;

  function automatic logic [CW-1:0] clamp_side(input logic [14:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e == '0) begin
      return CW'(1);
    end else if (e > CW'(MAX_SIDE)) begin
      return CW'(MAX_SIDE);
    end
    return e;
  endfunction

  // configuration: always ready, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_DXT1;
      width_q  <= 15'd1;
      height_q <= 15'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FORMAT: fmt_q    <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[14:0];
        REG_HEIGHT: height_q <= cfg_data_i[14:0];
        default:    ;
      endcase
    end
  end

  assign w_eff  = clamp_side(width_q);
  assign h_eff  = clamp_side(height_q);
  assign bx_cnt = ({1'b0, w_eff} + (CW+1)'(3)) >> 2;
  assign by_cnt = ({1'b0, h_eff} + (CW+1)'(3)) >> 2;
  assign base_x = (CW+1)'({col_q, 2'b00});
  assign base_y = (CW+1)'({row_q, 2'b00});
  assign rem_x  = {1'b0, w_eff} - base_x;
  assign rem_y  = {1'b0, h_eff} - base_y;

  // decode what the block needs before it reaches the palette stage
  always_comb begin
    unique case (fmt_q)
      FMT_DXT1: blk_d.fmt = FMT_DXT1;
      FMT_DXT3: blk_d.fmt = FMT_DXT3;
      default:  blk_d.fmt = FMT_DXT5;
    endcase
    blk_d.four = (fmt_q != FMT_DXT1) ||
                 (in_data_i.color_word[15:0] > in_data_i.color_word[31:16]);
    blk_d.e0   = expand565(in_data_i.color_word[15:0]);
    blk_d.e1   = expand565(in_data_i.color_word[31:16]);
    blk_d.cidx = in_data_i.color_word[63:32];
    blk_d.aw   = in_data_i.alpha_word;
    if (base_x >= {1'b0, w_eff}) begin
      blk_d.nx = 3'd0;
    end else if (rem_x >= (CW+1)'(4)) begin
      blk_d.nx = 3'd4;
    end else begin
      blk_d.nx = rem_x[2:0];
    end
    if (base_y >= {1'b0, h_eff}) begin
      blk_d.ny = 3'd0;
    end else if (rem_y >= (CW+1)'(4)) begin
      blk_d.ny = 3'd4;
    end else begin
      blk_d.ny = rem_y[2:0];
    end
  end

  // drop a fully clipped block without waiting for the sweep
  assign s1_vis     = (s1_blk_q.nx != 3'd0) && (s1_blk_q.ny != 3'd0);
  assign s1_take    = !s1_vis || em_stat.load_ready;
  assign in_stall_o = s1_valid_q && !s1_take;
  assign accept     = in_valid_i && !in_stall_o;

  assign col_inc = {1'b0, col_q} + (BLK_W+1)'(1);
  assign row_inc = {1'b0, row_q} + (BLK_W+1)'(1);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = s1_valid_q;
    if (s1_valid_q && s1_take) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      if ((CW+1)'(col_inc) >= bx_cnt) begin
        col_d = '0;
        if ((CW+1)'(row_inc) >= by_cnt) begin
          row_d = '0;
        end else begin
          row_d = row_inc[BLK_W-1:0];
        end
      end else begin
        col_d = col_inc[BLK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_blk_q <= blk_d;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  dxt_pal u_pal (
    .blk_i (s1_blk_q),
    .pal_o (pal)
  );

  dxt_emit #(
    .BLK_W (BLK_W)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q && s1_vis),
    .blk_i        (s1_blk_q),
    .pal_i        (pal),
    .col_i        (s1_col_q),
    .row_i        (s1_row_q),
    .stat_o       (em_stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  `DXT_ASSERT_IMPL(a_clipped_never_stalls, clk_i, rst_ni, s1_valid_q && !s1_vis, !in_stall_o)
  `DXT_ASSERT_IMPL(a_mid_block_keeps_sweep, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !out_data_o.block_end, em_stat.busy)
  `DXT_ASSERT_NEXT(a_row_moves_on_wrap, clk_i, rst_ni, accept,
                   (row_q == $past(row_q)) || (col_q == '0))

endmodule
